/* rtl/bbc_pkg.sv */
package bbc_pkg;

    localparam int NOW_W      = 32;
    localparam int POT_W      = 10;
    localparam int IVL_W      = 8;
    localparam int SPAN_W     = 8;
    localparam int PROD_W     = POT_W + SPAN_W;
    localparam int QUOT_W     = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W   = 48;
    localparam int M_DATA_W   = 32;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POT_PERIOD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_MIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_MAX  = 3'd4;

    localparam logic [15:0] DEBOUNCE_RST   = 16'd50;
    localparam logic [15:0] LONG_PRESS_RST = 16'd5000;
    localparam logic [15:0] POT_PERIOD_RST = 16'd1000;
    localparam logic [7:0]  BLINK_MIN_RST  = 8'd8;
    localparam logic [7:0]  BLINK_MAX_RST  = 8'd166;

    localparam logic [9:0]  POT_FULL_SCALE = 10'd1023;

    localparam logic [1:0] MODE_EV_NONE     = 2'd0;
    localparam logic [1:0] MODE_EV_PRESS    = 2'd1;
    localparam logic [1:0] MODE_EV_EARLY    = 2'd2;
    localparam logic [1:0] MODE_EV_SWITCHED = 2'd3;

    localparam logic [2:0] ACT_EV_NONE      = 3'd0;
    localparam logic [2:0] ACT_EV_BOUNCE    = 3'd1;
    localparam logic [2:0] ACT_EV_BLINK_ON  = 3'd2;
    localparam logic [2:0] ACT_EV_BLINK_OFF = 3'd3;
    localparam logic [2:0] ACT_EV_POT       = 3'd4;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] long_press_ms;
        logic [15:0] pot_period_ms;
        logic [7:0]  blink_min_ms;
        logic [7:0]  blink_max_ms;
    } cfg_t;

    // One polling pass, with the interval product already formed
    typedef struct packed {
        logic [NOW_W-1:0]  now_ms;
        logic              toggle_level;
        logic              mode_level;
        logic [POT_W-1:0]  pot_sample;
        logic [PROD_W-1:0] prod_mag;
        logic              prod_neg;
    } item_t;

    typedef struct packed {
        logic [POT_W-1:0] report_value;
        logic [2:0]       action_event;
        logic [1:0]       mode_event;
        logic [IVL_W-1:0] led_interval;
        logic             blink_on;
        logic             monitor_mode;
        logic             led_level;
    } result_t;

endpackage

/* rtl/bbc_in_stage.sv */
module bbc_in_stage (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // now_ms[31:0], toggle_level[32], mode_level[33], pot_sample[43:34], zero fill
    input  logic [bbc_pkg::S_DATA_W-1:0] s_tdata,
    input  bbc_pkg::cfg_t                cfg,
    input  logic                         advance,
    output logic                         item_valid,
    output bbc_pkg::item_t               item
);
    import bbc_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    item_t             item_reg;
    item_t             item_next;
    logic              load;
    logic signed [8:0] span;
    logic [SPAN_W-1:0] span_mag;

    assign s_tready = !valid_reg || advance;
    assign load     = s_tvalid && s_tready;

    // Signed span of the interval range; multiply its magnitude by the sample
    always_comb begin
        span     = $signed({1'b0, cfg.blink_max_ms}) - $signed({1'b0, cfg.blink_min_ms});
        span_mag = span[8] ? SPAN_W'(-span) : span[SPAN_W-1:0];

        item_next              = item_reg;
        item_next.now_ms       = s_tdata[31:0];
        item_next.toggle_level = s_tdata[32];
        item_next.mode_level   = s_tdata[33];
        item_next.pot_sample   = s_tdata[43:34];
        item_next.prod_mag     = PROD_W'(s_tdata[43:34]) * PROD_W'(span_mag);
        item_next.prod_neg     = span[8];

        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* rtl/bbc_map.sv */
module bbc_map (
    input  logic [bbc_pkg::PROD_W-1:0] prod_mag,
    input  logic                       prod_neg,
    input  logic [7:0]                 blink_min_ms,
    input  logic [7:0]                 blink_max_ms,
    output logic [bbc_pkg::IVL_W-1:0]  interval
);
    import bbc_pkg::*;

    logic [7:0]         q_est;
    logic [10:0]        rem;
    logic [QUOT_W-1:0]  quot;
    logic signed [10:0] offs;
    logic signed [10:0] val;
    logic signed [10:0] lo;
    logic signed [10:0] hi;

    // Divide by full scale: p/1024 is low by at most one, so fix with one compare.
    // Remainder of p - q_est*1023 is p[9:0] + q_est.
    always_comb begin
        q_est = prod_mag[PROD_W-1:10];
        rem   = {1'b0, prod_mag[9:0]} + {3'b0, q_est};
        quot  = {1'b0, q_est} + ((rem >= {1'b0, POT_FULL_SCALE}) ? 9'd1 : 9'd0);

        // Truncate toward zero: negate the magnitude quotient
        offs = prod_neg ? -$signed({2'b0, quot}) : $signed({2'b0, quot});
        lo   = $signed({3'b0, blink_min_ms});
        hi   = $signed({3'b0, blink_max_ms});
        val  = offs + lo;

        if (val < lo) begin
            val = lo;
        end else if (val > hi) begin
            val = hi;
        end
        interval = val[IVL_W-1:0];
    end

endmodule

/* rtl/bbc_ctrl.sv */
module bbc_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      advance,
    input  bbc_pkg::item_t            item,
    input  bbc_pkg::cfg_t             cfg,
    input  logic [bbc_pkg::IVL_W-1:0] mapped_interval,
    output bbc_pkg::result_t          result
);
    import bbc_pkg::*;

    logic             press_active_reg,     press_active_next;
    logic [NOW_W-1:0] press_start_reg,      press_start_next;
    logic             monitoring_reg,       monitoring_next;
    logic             stable_level_reg,     stable_level_next;
    logic [NOW_W-1:0] last_edge_time_reg,   last_edge_time_next;
    logic             blinking_reg,         blinking_next;
    logic             blink_phase_reg,      blink_phase_next;
    logic [NOW_W-1:0] last_toggle_time_reg, last_toggle_time_next;
    logic             pin_level_reg,        pin_level_next;
    logic [IVL_W-1:0] interval_reg,         interval_next;
    logic [NOW_W-1:0] last_report_time_reg, last_report_time_next;

    logic [NOW_W-1:0] press_elapsed;
    logic [NOW_W-1:0] edge_elapsed;
    logic [NOW_W-1:0] toggle_elapsed;
    logic [NOW_W-1:0] report_elapsed;
    logic [1:0]       mode_ev;
    logic [2:0]       act_ev;
    logic [POT_W-1:0] rep_val;

    assign press_elapsed  = item.now_ms - press_start_reg;
    assign edge_elapsed   = item.now_ms - last_edge_time_reg;
    assign toggle_elapsed = item.now_ms - last_toggle_time_reg;
    assign report_elapsed = item.now_ms - last_report_time_reg;

    always_comb begin
        press_active_next     = press_active_reg;
        press_start_next      = press_start_reg;
        monitoring_next       = monitoring_reg;
        stable_level_next     = stable_level_reg;
        last_edge_time_next   = last_edge_time_reg;
        blinking_next         = blinking_reg;
        blink_phase_next      = blink_phase_reg;
        last_toggle_time_next = last_toggle_time_reg;
        pin_level_next        = pin_level_reg;
        interval_next         = interval_reg;
        last_report_time_next = last_report_time_reg;
        mode_ev               = MODE_EV_NONE;
        act_ev                = ACT_EV_NONE;
        rep_val               = '0;

        // Mode button: long hold flips monitoring and restarts press timing
        if (!item.mode_level) begin
            if (!press_active_reg) begin
                press_active_next = 1'b1;
                press_start_next  = item.now_ms;
                mode_ev           = MODE_EV_PRESS;
            end else if (press_elapsed >= {16'b0, cfg.long_press_ms}) begin
                monitoring_next   = !monitoring_reg;
                pin_level_next    = 1'b0;
                press_active_next = 1'b0;
                mode_ev           = MODE_EV_SWITCHED;
            end
        end else if (press_active_reg) begin
            press_active_next = 1'b0;
            mode_ev           = MODE_EV_EARLY;
        end

        if (monitoring_next) begin
            if (report_elapsed >= {16'b0, cfg.pot_period_ms}) begin
                interval_next         = mapped_interval;
                act_ev                = ACT_EV_POT;
                rep_val               = item.pot_sample;
                last_report_time_next = item.now_ms;
            end
        end else begin
            if (item.toggle_level != stable_level_reg) begin
                if (edge_elapsed > {16'b0, cfg.debounce_ms}) begin
                    stable_level_next   = item.toggle_level;
                    last_edge_time_next = item.now_ms;
                    // Only the press edge toggles blinking
                    if (!item.toggle_level) begin
                        blinking_next = !blinking_reg;
                        if (!blinking_reg) begin
                            interval_next = mapped_interval;
                            act_ev        = ACT_EV_BLINK_ON;
                        end else begin
                            pin_level_next = 1'b0;
                            act_ev         = ACT_EV_BLINK_OFF;
                        end
                    end
                end else begin
                    act_ev = ACT_EV_BOUNCE;
                end
            end
            if (blinking_next && (toggle_elapsed >= {24'b0, interval_next})) begin
                blink_phase_next      = !blink_phase_reg;
                pin_level_next        = !blink_phase_reg;
                last_toggle_time_next = item.now_ms;
            end
        end

        result.led_level    = pin_level_next;
        result.monitor_mode = monitoring_next;
        result.blink_on     = blinking_next;
        result.led_interval = interval_next;
        result.mode_event   = mode_ev;
        result.action_event = act_ev;
        result.report_value = rep_val;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_active_reg     <= 1'b0;
            press_start_reg      <= '0;
            monitoring_reg       <= 1'b0;
            stable_level_reg     <= 1'b1;
            last_edge_time_reg   <= '0;
            blinking_reg         <= 1'b0;
            blink_phase_reg      <= 1'b0;
            last_toggle_time_reg <= '0;
            pin_level_reg        <= 1'b0;
            interval_reg         <= '0;
            last_report_time_reg <= '0;
        end else if (advance) begin
            press_active_reg     <= press_active_next;
            press_start_reg      <= press_start_next;
            monitoring_reg       <= monitoring_next;
            stable_level_reg     <= stable_level_next;
            last_edge_time_reg   <= last_edge_time_next;
            blinking_reg         <= blinking_next;
            blink_phase_reg      <= blink_phase_next;
            last_toggle_time_reg <= last_toggle_time_next;
            pin_level_reg        <= pin_level_next;
            interval_reg         <= interval_next;
            last_report_time_reg <= last_report_time_next;
        end
    end

endmodule

/* rtl/button_blink_controller.sv */
// Button and blink controller: each request is one polling pass (time, two
// active-low button levels, potentiometer sample) and gives exactly one result.
// A request passes an input register, where the interval product is formed,
// and then the control step, which updates all state and loads the result
// register in the same cycle. One request is taken per clock while m_tready
// holds high; a pass waits in the input register and its result then waits in
// the result register. Configuration writes take effect on the next clock and
// belong only to idle periods.
module button_blink_controller (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // now_ms[31:0], toggle_level[32], mode_level[33], pot_sample[43:34], zero fill
    input  logic [bbc_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // led_level[0], monitor_mode[1], blink_on[2], led_interval[10:3],
    // mode_event[12:11], action_event[15:13], report_value[25:16], zero fill
    output logic [bbc_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                           cfg_wr_en,
    input  logic [bbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bbc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import bbc_pkg::*;

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    item_t            item;
    logic             item_valid;
    logic             advance;
    logic [IVL_W-1:0] mapped_interval;
    result_t          result;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DEBOUNCE:   cfg_next.debounce_ms   = cfg_wdata;
                CFG_LONG_PRESS: cfg_next.long_press_ms = cfg_wdata;
                CFG_POT_PERIOD: cfg_next.pot_period_ms = cfg_wdata;
                CFG_BLINK_MIN:  cfg_next.blink_min_ms  = cfg_wdata[7:0];
                CFG_BLINK_MAX:  cfg_next.blink_max_ms  = cfg_wdata[7:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ms   <= DEBOUNCE_RST;
            cfg_reg.long_press_ms <= LONG_PRESS_RST;
            cfg_reg.pot_period_ms <= POT_PERIOD_RST;
            cfg_reg.blink_min_ms  <= BLINK_MIN_RST;
            cfg_reg.blink_max_ms  <= BLINK_MAX_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Step the pass whenever the result slot is free or being drained
    assign advance = item_valid && (!m_valid_reg || m_tready);

    bbc_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg        (cfg_reg),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    bbc_map u_map (
        .prod_mag     (item.prod_mag),
        .prod_neg     (item.prod_neg),
        .blink_min_ms (cfg_reg.blink_min_ms),
        .blink_max_ms (cfg_reg.blink_max_ms),
        .interval     (mapped_interval)
    );

    bbc_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .advance         (advance),
        .item            (item),
        .cfg             (cfg_reg),
        .mapped_interval (mapped_interval),
        .result          (result)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= M_DATA_W'(result);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
